### hw/rtl/tlsdp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the two-limit-switch debounce and position unit.
// No dependencies; used by the top level and the testbench.
package tlsdp_pkg;

   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned DebounceWidth = 16;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_OPEN_FITTED   = 2'd0,
      CSR_CLOSED_FITTED = 2'd1,
      CSR_ACTIVE_LOW    = 2'd2,
      CSR_DEBOUNCE_MS   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      POS_UNKNOWN = 2'd0,
      POS_OPEN    = 2'd1,
      POS_CLOSED  = 2'd2
   } door_position_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 open_level;
      logic                 closed_level;
   } req_payload_type;

   typedef struct packed {
      logic              open_made;
      logic              closed_made;
      logic              both_made_fault;
      logic              sensing_enabled;
      door_position_type door_position;
   } rsp_payload_type;

   typedef struct packed {
      logic                 stable;
      logic                 candidate;
      logic [TimeWidth-1:0] since;
   } switch_state_type;

endpackage

### hw/rtl/tlsdp_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload struct per transfer.
// The payload type comes in as a parameter, normally a struct from tlsdp_pkg.
interface tlsdp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/two_limit_switch_debounce_position_unit.sv
`timescale 1ns / 1ps
// Debounces an open-end and a closed-end limit switch from timestamped ticks and
// reports the door position. A tick is taken into an input register, then one
// pass of logic updates both debouncers and loads the result register, from which
// each tick's result is offered once that register is free, and a new tick can be
// taken in every cycle while results are drained. A level must persist for
// debounce_ms of tick time (signed wrapping difference) before it is believed.
// Any configuration write clears both debouncers. Depends on tlsdp_pkg and
// tlsdp_stream_if.
module two_limit_switch_debounce_position_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   tlsdp_stream_if.sink                            req_chan,
   tlsdp_stream_if.source                          rsp_chan,
   input  logic                                    csr_wr_en,
   input  logic [tlsdp_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [tlsdp_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import tlsdp_pkg::*;

   // Configuration registers.
   logic                     open_fitted_ff,   open_fitted_in;
   logic                     closed_fitted_ff, closed_fitted_in;
   logic                     active_low_ff,    active_low_in;
   logic [DebounceWidth-1:0] debounce_ms_ff,   debounce_ms_in;
   logic                     csr_clear;

   // Debouncer state.
   switch_state_type open_sw_ff,   open_sw_in;
   switch_state_type closed_sw_ff, closed_sw_in;

   // Input and result stages.
   logic            in_valid_ff,  in_valid_in;
   req_payload_type in_data_ff,   in_data_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff,  out_data_in;

   logic            req_xfer;
   logic            advance;

   function automatic switch_state_type step_switch(
      input switch_state_type     cur,
      input logic                 fitted,
      input logic                 level,
      input logic                 low_active,
      input logic [TimeWidth-1:0] now,
      input logic [DebounceWidth-1:0] interval
   );
      switch_state_type     nxt;
      logic                 made;
      logic [TimeWidth-1:0] diff;
      nxt  = cur;
      made = level ^ low_active;
      diff = now - cur.since;
      if (!fitted) begin
         nxt.stable    = 1'b0;
         nxt.candidate = 1'b0;
      end else if (made != cur.candidate) begin
         nxt.candidate = made;
         nxt.since     = now;
      end else if ((cur.candidate != cur.stable) && !diff[TimeWidth-1] &&
                   (diff >= TimeWidth'(interval))) begin
         nxt.stable = cur.candidate;
      end
      return nxt;
   endfunction

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   always_comb begin
      open_fitted_in   = open_fitted_ff;
      closed_fitted_in = closed_fitted_ff;
      active_low_in    = active_low_ff;
      debounce_ms_in   = debounce_ms_ff;
      csr_clear        = 1'b0;
      if (csr_wr_en) begin
         csr_clear = 1'b1;
         unique case (csr_index_type'(csr_index))
            CSR_OPEN_FITTED:   open_fitted_in   = csr_wdata[0];
            CSR_CLOSED_FITTED: closed_fitted_in = csr_wdata[0];
            CSR_ACTIVE_LOW:    active_low_in    = csr_wdata[0];
            CSR_DEBOUNCE_MS:   debounce_ms_in   = csr_wdata;
            default:           csr_clear        = 1'b0;
         endcase
      end
   end

   always_comb begin
      switch_state_type open_nxt;
      switch_state_type closed_nxt;
      logic             fault;
      logic             enabled;

      open_nxt = step_switch(open_sw_ff, open_fitted_ff, in_data_ff.open_level,
                             active_low_ff, in_data_ff.now_ms, debounce_ms_ff);
      closed_nxt = step_switch(closed_sw_ff, closed_fitted_ff, in_data_ff.closed_level,
                               active_low_ff, in_data_ff.now_ms, debounce_ms_ff);
      enabled = open_fitted_ff || closed_fitted_ff;
      fault   = open_nxt.stable && closed_nxt.stable;

      out_data_in                 = out_data_ff;
      out_data_in.open_made       = open_nxt.stable;
      out_data_in.closed_made     = closed_nxt.stable;
      out_data_in.both_made_fault = fault;
      out_data_in.sensing_enabled = enabled;
      priority if (!enabled || fault) begin
         out_data_in.door_position = POS_UNKNOWN;
      end else if (open_nxt.stable) begin
         out_data_in.door_position = POS_OPEN;
      end else if (closed_nxt.stable) begin
         out_data_in.door_position = POS_CLOSED;
      end else begin
         out_data_in.door_position = POS_UNKNOWN;
      end
      if (!advance) begin
         out_data_in = out_data_ff;
      end

      open_sw_in   = open_sw_ff;
      closed_sw_in = closed_sw_ff;
      if (csr_clear) begin
         open_sw_in   = '0;
         closed_sw_in = '0;
      end else if (advance) begin
         open_sw_in   = open_nxt;
         closed_sw_in = closed_nxt;
      end
   end

   always_comb begin
      in_data_in   = req_xfer ? req_chan.payload : in_data_ff;
      in_valid_in  = req_xfer || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_fitted_ff   <= 1'b0;
         closed_fitted_ff <= 1'b0;
         active_low_ff    <= 1'b1;
         debounce_ms_ff   <= DebounceWidth'(50);
         open_sw_ff       <= '0;
         closed_sw_ff     <= '0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         open_fitted_ff   <= open_fitted_in;
         closed_fitted_ff <= closed_fitted_in;
         active_low_ff    <= active_low_in;
         debounce_ms_ff   <= debounce_ms_in;
         open_sw_ff       <= open_sw_in;
         closed_sw_ff     <= closed_sw_in;
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the two-limit-switch debounce and position unit.
// Depends on tlsdp_pkg, tlsdp_stream_if and the unit itself. Predicts each
// reading from the ticks transferred in and compares it with the unit's output.
module testbench;
   import tlsdp_pkg::*;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned PhaseTicks  = 260;
   localparam int unsigned DrainCycles = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   tlsdp_stream_if #(.payload_type(req_payload_type)) req_if ();
   tlsdp_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   two_limit_switch_debounce_position_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Predictor copy of the configuration and of both debouncers.
   logic                     cfg_open_fitted   = 1'b0;
   logic                     cfg_closed_fitted = 1'b0;
   logic                     cfg_active_low    = 1'b1;
   logic [DebounceWidth-1:0] cfg_debounce_ms   = 16'd50;
   switch_state_type         open_sw   = '0;
   switch_state_type         closed_sw = '0;

   req_payload_type pending_ticks[$];
   rsp_payload_type expected_readings[$];
   int unsigned     ticks_queued   = 0;
   int unsigned     ticks_taken    = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count    = 0;
   bit              steady_flow    = 1'b0;

   // Stimulus state for the random part.
   logic [TimeWidth-1:0] tick_now_ms = '0;
   logic                 hold_open   = 1'b0;
   logic                 hold_closed = 1'b0;

   function automatic void step_switch(inout switch_state_type sw, input logic fitted,
                                       input logic level, input logic [TimeWidth-1:0] now);
      logic                 made;
      logic [TimeWidth-1:0] elapsed;
      if (!fitted) begin
         sw.stable    = 1'b0;
         sw.candidate = 1'b0;
         return;
      end
      made = cfg_active_low ? !level : level;
      if (made != sw.candidate) begin
         sw.candidate = made;
         sw.since     = now;
         return;
      end
      // A negative wrapped difference means time went backwards; keep the old level.
      elapsed = now - sw.since;
      if (sw.candidate != sw.stable && !elapsed[TimeWidth-1] &&
          elapsed >= {{(TimeWidth-DebounceWidth){1'b0}}, cfg_debounce_ms}) begin
         sw.stable = sw.candidate;
      end
   endfunction

   function automatic rsp_payload_type predict_reading(input req_payload_type tick);
      rsp_payload_type reading;
      step_switch(open_sw, cfg_open_fitted, tick.open_level, tick.now_ms);
      step_switch(closed_sw, cfg_closed_fitted, tick.closed_level, tick.now_ms);
      reading.open_made       = open_sw.stable;
      reading.closed_made     = closed_sw.stable;
      reading.both_made_fault = open_sw.stable && closed_sw.stable;
      reading.sensing_enabled = cfg_open_fitted || cfg_closed_fitted;
      if (!reading.sensing_enabled || reading.both_made_fault) begin
         reading.door_position = POS_UNKNOWN;
      end else if (open_sw.stable) begin
         reading.door_position = POS_OPEN;
      end else if (closed_sw.stable) begin
         reading.door_position = POS_CLOSED;
      end else begin
         reading.door_position = POS_UNKNOWN;
      end
      return reading;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_reading(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_readings.size() == 0) begin
         report_mismatch("reading arrived with no tick outstanding");
         return;
      end
      want = expected_readings.pop_front();
      if (got.open_made !== want.open_made)
         report_mismatch($sformatf("open_made got %b want %b", got.open_made, want.open_made));
      if (got.closed_made !== want.closed_made)
         report_mismatch($sformatf("closed_made got %b want %b",
                                   got.closed_made, want.closed_made));
      if (got.both_made_fault !== want.both_made_fault)
         report_mismatch($sformatf("both_made_fault got %b want %b",
                                   got.both_made_fault, want.both_made_fault));
      if (got.sensing_enabled !== want.sensing_enabled)
         report_mismatch($sformatf("sensing_enabled got %b want %b",
                                   got.sensing_enabled, want.sensing_enabled));
      if (got.door_position !== want.door_position)
         report_mismatch($sformatf("door_position got %0d want %0d",
                                   got.door_position, want.door_position));
   endtask

   // Driver: presents the next pending tick once the previous one has transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_ticks.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 10)) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= pending_ticks.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each tick transfer and checks each reading transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_readings.push_back(predict_reading(req_if.payload));
            ticks_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            check_reading(rsp_if.payload);
         end
         rsp_if.ready <= steady_flow || ($urandom_range(0, 99) >= 10);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_tick(input logic [TimeWidth-1:0] now, input logic open_level,
                            input logic closed_level);
      req_payload_type tick;
      tick.now_ms       = now;
      tick.open_level   = open_level;
      tick.closed_level = closed_level;
      pending_ticks.push_back(tick);
      ticks_queued++;
   endtask

   // Any write clears both debouncers, in the unit and in the predictor.
   task automatic write_register(input csr_index_type index, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_OPEN_FITTED:   cfg_open_fitted   = value[0];
         CSR_CLOSED_FITTED: cfg_closed_fitted = value[0];
         CSR_ACTIVE_LOW:    cfg_active_low    = value[0];
         CSR_DEBOUNCE_MS:   cfg_debounce_ms   = value;
         default: ;
      endcase
      open_sw   = '0;
      closed_sw = '0;
   endtask

   task automatic apply_settings(input logic open_fitted, input logic closed_fitted,
                                 input logic active_low, input logic [15:0] debounce_ms);
      write_register(CSR_OPEN_FITTED, {15'd0, open_fitted});
      write_register(CSR_CLOSED_FITTED, {15'd0, closed_fitted});
      write_register(CSR_ACTIVE_LOW, {15'd0, active_low});
      write_register(CSR_DEBOUNCE_MS, debounce_ms);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sampled on the falling edge so the monitor's counters have settled.
   task automatic wait_until_drained;
      @(negedge clock);
      while (pending_ticks.size() != 0 || ticks_taken != ticks_queued ||
             expected_readings.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Mostly held levels with time moving forward, so debouncing completes, plus
   // single-tick bounces, backward steps and arbitrary jumps of the timestamp.
   task automatic queue_random_ticks(input int unsigned count);
      int unsigned span;
      int unsigned roll;
      span = (cfg_debounce_ms >> 2) + 2;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            tick_now_ms = $urandom;
         end else if (roll < 7) begin
            tick_now_ms = tick_now_ms - $urandom_range(1, span);
         end else begin
            tick_now_ms = tick_now_ms + $urandom_range(0, span);
         end
         if ($urandom_range(0, 11) == 0) hold_open = !hold_open;
         if ($urandom_range(0, 11) == 0) hold_closed = !hold_closed;
         push_tick(tick_now_ms, hold_open ^ ($urandom_range(0, 9) == 0),
                   hold_closed ^ ($urandom_range(0, 9) == 0));
      end
   endtask

   task automatic run_phase(input logic open_fitted, input logic closed_fitted,
                            input logic active_low, input logic [15:0] debounce_ms);
      wait_until_drained();
      apply_settings(open_fitted, closed_fitted, active_low, debounce_ms);
      queue_random_ticks(PhaseTicks);
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: nothing fitted, so levels are ignored.
      push_tick(32'h0000_0000, 1'b0, 1'b0);
      push_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
      wait_until_drained();

      // Both fitted, high level means made, short interval.
      apply_settings(1'b1, 1'b1, 1'b0, 16'd10);
      push_tick(32'd100, 1'b1, 1'b0);
      push_tick(32'd105, 1'b1, 1'b0);
      push_tick(32'd110, 1'b1, 1'b0);
      push_tick(32'd111, 1'b1, 1'b1);
      push_tick(32'd121, 1'b1, 1'b1);   // both made: fault
      push_tick(32'd122, 1'b0, 1'b1);
      push_tick(32'd140, 1'b0, 1'b1);   // closed only
      push_tick(32'd130, 1'b0, 1'b0);
      push_tick(32'd120, 1'b0, 1'b0);   // time went backwards
      push_tick(32'd129, 1'b0, 1'b0);
      push_tick(32'd140, 1'b0, 1'b0);
      push_tick(32'hFFFF_FFFA, 1'b1, 1'b0);
      push_tick(32'h0000_0004, 1'b1, 1'b0);   // interval reached across the wrap
      wait_until_drained();

      // Zero interval: a new level is believed on the next tick.
      apply_settings(1'b1, 1'b1, 1'b0, 16'd0);
      push_tick(32'd7, 1'b1, 1'b0);
      push_tick(32'd7, 1'b1, 1'b0);
      push_tick(32'd7, 1'b0, 1'b1);
      push_tick(32'd7, 1'b0, 1'b1);

      run_phase(1'b1, 1'b1, 1'b1, 16'd50);
      run_phase(1'b1, 1'b0, 1'b0, 16'd3);
      steady_flow = 1'b1;
      run_phase(1'b0, 1'b1, 1'b1, 16'd1);
      wait_until_drained();
      steady_flow = 1'b0;
      tick_now_ms = 32'hFFFF_F000;
      run_phase(1'b1, 1'b1, 1'b0, 16'd0);
      run_phase(1'b0, 1'b0, 1'b0, 16'd20);
      run_phase(1'b1, 1'b1, 1'b1, 16'hFFFF);
      run_phase(1'b1, 1'b1, 1'b0, 16'd200);

      wait_until_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
